### hw/rtl/rtwt_pkg.sv
// rtwt_pkg: shared types and constants for the request timeout watchdog table
// used by rtwt_cell, request_timeout_watchdog_table and rtwt_checker
// no dependencies

package rtwt_pkg;

  // operation codes on the input word
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam int unsigned SLOTS_DEF = 256;
  localparam logic [15:0] ID_LIMIT  = 16'hF000;
  localparam logic [8:0]  COUNT_MAX = 9'd511;

  // command word that walks down the row of cells
  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic [31:0] now;
    logic [15:0] id;
    logic        hit;
  } tok_t;

endpackage

### hw/rtl/rtwt_cell.sv
// rtwt_cell: one table slot (used mark, id, start time) in the scan chain
// depends on rtwt_pkg (tok_t, operation codes)

module rtwt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic [31:0]        timeout,
  input  rtwt_pkg::tok_t     tok_in,
  output rtwt_pkg::tok_t     tok_out_r
);

  logic           used_r;
  logic           used_nxt;
  logic [15:0]    id_r;
  logic [31:0]    start_r;
  logic [31:0]    age;
  logic           take;
  logic           drop;
  logic           over;
  rtwt_pkg::tok_t tok_out_nxt;

  assign age  = tok_in.now - start_r;
  assign take = tok_in.vld && (tok_in.op == rtwt_pkg::OP_APPEND) && !tok_in.hit && !used_r;
  assign drop = tok_in.vld && (tok_in.op == rtwt_pkg::OP_REMOVE) && !tok_in.hit && used_r
                && (id_r == tok_in.id);
  assign over = tok_in.vld && (tok_in.op == rtwt_pkg::OP_TICK) && used_r && (age > timeout);

  always_comb begin
    used_nxt = used_r;
    if (clr) begin
      used_nxt = 1'b0;
    end else if (take) begin
      used_nxt = 1'b1;
    end else if (drop) begin
      used_nxt = 1'b0;
    end
    tok_out_nxt     = tok_in;
    tok_out_nxt.hit = tok_in.hit | take | drop | over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r        <= 1'b0;
      tok_out_r.vld <= 1'b0;
    end else begin
      used_r        <= used_nxt;
      tok_out_r.vld <= tok_out_nxt.vld;
    end
    // payload of the passing word
    tok_out_r.op  <= tok_out_nxt.op;
    tok_out_r.now <= tok_out_nxt.now;
    tok_out_r.id  <= tok_out_nxt.id;
    tok_out_r.hit <= tok_out_nxt.hit;
  end

  // payload of the slot
  always_ff @(posedge clk) begin
    if (take) begin
      id_r    <= tok_in.id;
      start_r <= tok_in.now;
    end
  end

endmodule

### hw/rtl/request_timeout_watchdog_table.sv
// request_timeout_watchdog_table: pending request table with timeout watchdog
// depends on rtwt_pkg and rtwt_cell
//
//   channel | ports                                               | direction
//   in      | in_valid/in_ready, operation, now_time, request_id, | in
//           | session_present                                     |
//   out     | out_valid/out_ready, assigned_id, timed_out,        | out
//           | active_count                                        |
//   cfg     | cfg_we, cfg_wdata (inactivity timeout)              | in
//
// an append or a tick with a session, or a remove with a nonzero id, goes from
// the launch register down the row of cells, one slot per cycle, and then through
// the done state to the output register; other words go straight to the done state
// one word is in flight at a time; in_ready is high whenever the row is idle,
// even while the previous result still waits in the output register
// reset (synchronous, active low) clears all used marks, the id sequence,
// the pending count and the timeout at once; no clearing pass is needed
// a stalled output holds its word; a finished word waits in the done state

module request_timeout_watchdog_table #(
  parameter int unsigned SLOTS = rtwt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_now_time,
  input  logic [15:0] in_request_id,
  input  logic        in_session_present,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_assigned_id,
  output logic        out_timed_out,
  output logic [8:0]  out_active_count,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  // controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [31:0]    timeout_r;
  logic [15:0]    seq_r, seq_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [15:0]    new_id_r, new_id_nxt;
  rtwt_pkg::tok_t launch_r, launch_nxt;
  logic [15:0]    res_id_r, res_id_nxt;
  logic           res_to_r, res_to_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_id_r;
  logic           out_to_r;
  logic [8:0]     out_cnt_r;
  logic [8:0]     cnt_sat;
  logic [16:0]    seq_inc;
  logic [15:0]    next_id;
  logic           in_acc;
  logic           clr;
  logic           scan_end;
  logic           out_free;

  // links between cells: link[0] is the launch register, link[SLOTS] the tail
  rtwt_pkg::tok_t link [SLOTS+1];

  assign link[0] = launch_r;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      rtwt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .timeout   (timeout_r),
        .tok_in    (link[g]),
        .tok_out_r (link[g+1])
      );
    end
  endgenerate

  // next id in the sequence 1..0xF000
  assign seq_inc = {1'b0, seq_r} + 17'd1;
  assign next_id = (seq_inc > {1'b0, rtwt_pkg::ID_LIMIT}) ? 16'd1 : seq_inc[15:0];

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign scan_end = (state_r == ST_SCAN) && link[SLOTS].vld;
  // a tick that found an over-age entry wipes every slot at once
  assign clr      = scan_end && (op_r == rtwt_pkg::OP_TICK) && link[SLOTS].hit;
  assign out_free = !out_valid_r || out_ready;

  assign cnt_sat  = (count_r > CW'(rtwt_pkg::COUNT_MAX)) ? rtwt_pkg::COUNT_MAX : 9'(count_r);

  always_comb begin
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    new_id_nxt     = new_id_r;
    launch_nxt     = launch_r;
    launch_nxt.vld = 1'b0;
    res_id_nxt     = res_id_r;
    res_to_nxt     = res_to_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_operation;
          new_id_nxt     = next_id;
          res_id_nxt     = 16'd0;
          res_to_nxt     = 1'b0;
          launch_nxt.op  = in_operation;
          launch_nxt.now = in_now_time;
          launch_nxt.id  = (in_operation == rtwt_pkg::OP_APPEND) ? next_id : in_request_id;
          launch_nxt.hit = 1'b0;
          if (((in_operation == rtwt_pkg::OP_APPEND) && in_session_present) ||
              ((in_operation == rtwt_pkg::OP_REMOVE) && (in_request_id != 16'd0)) ||
              ((in_operation == rtwt_pkg::OP_TICK) && in_session_present)) begin
            launch_nxt.vld = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            // nothing to scan: report the current count as is
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
          if (link[SLOTS].hit) begin
            case (op_r)
              rtwt_pkg::OP_APPEND: begin
                seq_nxt    = new_id_r;
                count_nxt  = count_r + CW'(1);
                res_id_nxt = new_id_r;
              end
              rtwt_pkg::OP_REMOVE: begin
                if (count_r != '0) begin
                  count_nxt = count_r - CW'(1);
                end
              end
              default: begin
                count_nxt  = '0;
                res_to_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      timeout_r    <= 32'd0;
      seq_r        <= 16'd0;
      count_r      <= '0;
      launch_r.vld <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seq_r        <= seq_nxt;
      count_r      <= count_nxt;
      launch_r.vld <= launch_nxt.vld;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
    // launch payload, no reset
    launch_r.op   <= launch_nxt.op;
    launch_r.now  <= launch_nxt.now;
    launch_r.id   <= launch_nxt.id;
    launch_r.hit  <= launch_nxt.hit;
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    new_id_r      <= new_id_nxt;
    res_id_r      <= res_id_nxt;
    res_to_r      <= res_to_nxt;
    if ((state_r == ST_DONE) && out_free) begin
      out_id_r  <= res_id_r;
      out_to_r  <= res_to_r;
      out_cnt_r <= cnt_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_assigned_id  = out_id_r;
  assign out_timed_out    = out_to_r;
  assign out_active_count = out_cnt_r;

endmodule

### hw/rtl/rtwt_checker.sv
// rtwt_checker: port-level assertions for request_timeout_watchdog_table
// depends on rtwt_pkg; bound to the top level at the end of this file

module rtwt_checker #(
  parameter int unsigned SLOTS = rtwt_pkg::SLOTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_assigned_id,
  input logic        out_timed_out,
  input logic [8:0]  out_active_count
);

  // one word in flight: accepting closes the input until the result moves to the output register
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a timeout empties the table and never comes with a new id
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> (out_active_count == 9'd0) && (out_assigned_id == 16'd0))
    else $error("timeout reported with entries or id");

  // issued ids stay inside the sequence range
  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_assigned_id <= rtwt_pkg::ID_LIMIT))
    else $error("assigned id out of range");

  // a new id means the table holds at least one entry
  a_id_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_assigned_id != 16'd0) |-> (out_active_count != 9'd0))
    else $error("id issued with empty table");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_assigned_id) &&
      $stable(out_timed_out) && $stable(out_active_count))
    else $error("stalled result word changed");

endmodule

bind request_timeout_watchdog_table rtwt_checker #(.SLOTS(SLOTS)) u_rtwt_checker (.*);
